FILE: hdl/pfs_pkg.sv
// package for the pell fundamental solution block
// shared types, status codes and controller states; no dependencies
package pfs_pkg;

  localparam logic [1:0] ST_FOUND    = 2'd0;
  localparam logic [1:0] ST_INVALID  = 2'd1;
  localparam logic [1:0] ST_OVERFLOW = 2'd2;

  localparam logic [6:0] STEP_LIMIT = 7'd127;

  typedef enum logic [3:0] {
    S_IDLE, S_SQRT, S_CHECK, S_MN, S_DN_MUL, S_DN_DIV, S_TEST,
    S_A_DIV, S_A_WAIT, S_CONV_P, S_P_WAIT, S_CONV_Q, S_Q_WAIT,
    S_CONV_CHK, S_DONE
  } ctrl_state_t;

  // commands from controller to datapath
  typedef struct packed {
    logic load;
    logic sqrt_start;
    logic calc_mn;
    logic calc_sq;
    logic div_dn_start;
    logic div_a_start;
    logic step_inc;
    logic mul_p_start;
    logic conv_p;
    logic mul_q_start;
    logic conv_q;
    logic commit;
    logic set_found;
    logic set_invalid;
    logic set_overflow;
    logic out_load;
  } dp_cmd_t;

  // status from datapath to controller
  typedef struct packed {
    logic busy;
    logic is_invalid;
    logic p_too_wide;
    logic dn_is_one;
    logic k_odd;
    logic k_at_limit;
    logic conv_ovf;
    logic out_full;
  } dp_stat_t;

endpackage

FILE: hdl/pfs_divider.sv
// iterative restoring divider, one quotient bit per cycle
// uses no package items
module pfs_divider #(
  parameter int WIDTH = 64
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  input  logic [WIDTH-1:0] dividend,
  input  logic [WIDTH-1:0] divisor,
  output logic             busy,
  output logic [WIDTH-1:0] quotient
);
  localparam int CW = $clog2(WIDTH + 1);

  logic [WIDTH-1:0] rem;
  logic [WIDTH-1:0] quo;
  logic [WIDTH-1:0] dvs;
  logic [CW-1:0]    cnt;
  logic [WIDTH:0]   trial;

  assign trial = {rem, quo[WIDTH-1]} - {1'b0, dvs};
  assign quotient = quo;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      cnt  <= '0;
    end else if (start) begin
      busy <= 1'b1;
      cnt  <= CW'(WIDTH);
      rem  <= '0;
      quo  <= dividend;
      dvs  <= divisor;
    end else if (busy) begin
      if (!trial[WIDTH]) begin
        rem <= trial[WIDTH-1:0];
        quo <= {quo[WIDTH-2:0], 1'b1};
      end else begin
        rem <= {rem[WIDTH-2:0], quo[WIDTH-1]};
        quo <= {quo[WIDTH-2:0], 1'b0};
      end
      cnt <= cnt - 1'b1;
      if (cnt == CW'(1)) begin
        busy <= 1'b0;
      end
    end
  end
endmodule

FILE: hdl/pfs_datapath.sv
// datapath: isqrt, continued fraction recurrence, convergents and result register
// depends on pfs_pkg and pfs_divider
module pfs_datapath #(
  parameter int N_WIDTH      = 32,
  parameter int RESULT_WIDTH = 64
) (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       n_in,
  input  pfs_pkg::dp_cmd_t  cmd,
  input  logic              out_fire,
  output pfs_pkg::dp_stat_t stat,
  output logic              out_valid,
  output logic [63:0]       x_out,
  output logic [63:0]       y_out,
  output logic [1:0]        status_out,
  output logic [6:0]        step_out
);
  import pfs_pkg::*;

  localparam int NW = N_WIDTH;
  localparam int RW = RESULT_WIDTH;
  // a0, m, d and every partial quotient stay at or below 2 * a0
  localparam int SW = (NW + 1) / 2 + 1;
  localparam int SQ_STEPS = (NW + 1) / 2;

  logic [NW-1:0]    n;
  logic [NW-1:0]    sq_v;
  logic [NW-1:0]    sq_res;
  logic [NW+1:0]    sq_bit;
  logic [NW+1:0]    sq_sum;
  logic [NW+1:0]    sq_res_next;
  logic             sq_take;
  logic [5:0]       sq_cnt;
  logic             sq_busy;
  logic [SW-1:0]    a0;
  logic [SW-1:0]    m;
  logic [SW-1:0]    d;
  logic [SW-1:0]    a;
  logic [SW-1:0]    mn;
  logic [SW-1:0]    dn;
  logic [2*SW-1:0]  a0_sq;
  logic [2*SW-1:0]  mn_sq;
  logic [NW-1:0]    num;
  logic [RW-1:0]    p, pp, q, qp, np;
  logic [63:0]      x, y;
  logic [6:0]       k;
  logic             ovf;
  logic [1:0]       st;
  logic             div_start;
  logic [NW-1:0]    div_dvd, div_dvs, div_q;
  logic             div_busy;

  // shift-add multiplier shared by both convergent updates, one bit of a per cycle
  logic             mul_start;
  logic             mul_busy;
  logic [5:0]       mul_cnt;
  logic [RW-1:0]    mul_op;
  logic [RW-1:0]    mul_mcand;
  logic [RW+SW-1:0] prod;
  logic [RW:0]      mul_psum;
  logic [RW:0]      sum;
  logic [RW-1:0]    conv_prev;
  logic             conv_wide;

  assign sq_sum      = {2'b0, sq_res} + sq_bit;
  assign sq_take     = ({2'b0, sq_v} >= sq_sum);
  assign sq_res_next = sq_take ? ({2'b0, sq_res} >> 1) + sq_bit : ({2'b0, sq_res} >> 1);

  assign a0_sq = a0 * a0;
  assign mn_sq = mn * mn;

  assign mul_start = cmd.mul_p_start | cmd.mul_q_start;
  assign mul_op    = cmd.mul_q_start ? q : p;
  assign mul_psum  = {1'b0, prod[RW+SW-1:SW]} + (prod[0] ? {1'b0, mul_mcand} : '0);
  assign conv_prev = cmd.conv_q ? qp : pp;
  assign sum       = {1'b0, prod[RW-1:0]} + {1'b0, conv_prev};
  assign conv_wide = sum[RW] || (prod[RW+SW-1:RW] != '0);

  assign div_start = cmd.div_dn_start | cmd.div_a_start;
  assign div_dvd   = cmd.div_dn_start ? num : NW'(a0) + NW'(m);
  assign div_dvs   = NW'(d);
  assign dn        = SW'(div_q);

  pfs_divider #(.WIDTH(NW)) u_div (
    .clk(clk), .rst(rst), .start(div_start), .dividend(div_dvd),
    .divisor(div_dvs), .busy(div_busy), .quotient(div_q)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      sq_busy   <= 1'b0;
      mul_busy  <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (cmd.sqrt_start) begin
        sq_busy <= 1'b1;
      end else if (sq_busy && sq_cnt == 6'd1) begin
        sq_busy <= 1'b0;
      end
      if (mul_start) begin
        mul_busy <= 1'b1;
      end else if (mul_busy && mul_cnt == 6'd1) begin
        mul_busy <= 1'b0;
      end
      if (cmd.out_load) begin
        out_valid <= 1'b1;
      end else if (out_fire) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      n   <= NW'(n_in);
      m   <= '0;
      d   <= SW'(1);
      pp  <= RW'(1);
      q   <= RW'(1);
      qp  <= '0;
      k   <= '0;
      ovf <= 1'b0;
      x   <= '0;
      y   <= '0;
      st  <= ST_FOUND;
    end
    if (cmd.sqrt_start) begin
      sq_v   <= n;
      sq_res <= '0;
      sq_bit <= (NW+2)'(1) << (2 * SQ_STEPS - 2);
      sq_cnt <= 6'(SQ_STEPS);
    end else if (sq_busy) begin
      if (sq_take) begin
        sq_v <= NW'({2'b0, sq_v} - sq_sum);
      end
      sq_res <= NW'(sq_res_next);
      sq_bit <= sq_bit >> 2;
      sq_cnt <= sq_cnt - 6'd1;
      if (sq_cnt == 6'd1) begin
        a0 <= SW'(sq_res_next);
        a  <= SW'(sq_res_next);
        p  <= RW'(sq_res_next);
      end
    end
    if (mul_start) begin
      prod      <= {{RW{1'b0}}, a};
      mul_mcand <= mul_op;
      mul_cnt   <= 6'(SW);
    end else if (mul_busy) begin
      prod    <= {mul_psum, prod[SW-1:1]};
      mul_cnt <= mul_cnt - 6'd1;
    end
    if (cmd.calc_mn) begin
      mn <= a * d - m;
    end
    if (cmd.calc_sq) begin
      num <= n - NW'(mn_sq);
    end
    if (cmd.commit) begin
      m <= mn;
      d <= dn;
    end
    if (cmd.div_a_start) begin
      k <= k + 7'd1;
    end
    if (cmd.step_inc) begin
      a <= SW'(div_q);
    end
    if (cmd.conv_p) begin
      np <= sum[RW-1:0];
      if (conv_wide) begin
        ovf <= 1'b1;
      end
    end
    if (cmd.conv_q) begin
      if (conv_wide) begin
        ovf <= 1'b1;
      end else begin
        pp <= p;
        p  <= np;
        qp <= q;
        q  <= sum[RW-1:0];
      end
    end
    if (cmd.set_found) begin
      x  <= 64'(p);
      y  <= 64'(q);
      st <= ST_FOUND;
    end
    if (cmd.set_invalid) begin
      st <= ST_INVALID;
    end
    if (cmd.set_overflow) begin
      st <= ST_OVERFLOW;
    end
    if (cmd.out_load) begin
      x_out      <= x;
      y_out      <= y;
      status_out <= st;
      step_out   <= k;
    end
  end

  assign stat.busy       = sq_busy | div_busy | mul_busy;
  assign stat.is_invalid = (n == '0) || (a0_sq == (2*SW)'(n));
  // a0 alone may not fit when the result width is narrow
  assign stat.p_too_wide = ((a0 >> RW) != '0);
  assign stat.dn_is_one  = (dn == SW'(1));
  assign stat.k_odd      = k[0];
  assign stat.k_at_limit = (k >= STEP_LIMIT);
  assign stat.conv_ovf   = ovf;
  assign stat.out_full   = out_valid;
endmodule

FILE: hdl/pfs_controller.sv
// controller state machine sequencing one item through the datapath
// depends on pfs_pkg
module pfs_controller (
  input  logic              clk,
  input  logic              rst,
  input  logic              in_fire,
  input  pfs_pkg::dp_stat_t stat,
  output pfs_pkg::dp_cmd_t  cmd,
  output logic              in_ready
);
  import pfs_pkg::*;

  ctrl_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    cmd        = '0;
    in_ready   = (state == S_IDLE);
    case (state)
      S_IDLE: begin
        if (in_fire) begin
          cmd.load   = 1'b1;
          state_next = S_SQRT;
        end
      end
      S_SQRT: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_CHECK;
      end
      S_CHECK: begin
        if (!stat.busy) begin
          if (stat.is_invalid) begin
            cmd.set_invalid = 1'b1;
            state_next      = S_DONE;
          end else if (stat.p_too_wide) begin
            cmd.set_overflow = 1'b1;
            state_next       = S_DONE;
          end else begin
            state_next = S_MN;
          end
        end
      end
      S_MN: begin
        cmd.calc_mn = 1'b1;
        state_next  = S_DN_MUL;
      end
      S_DN_MUL: begin
        cmd.calc_sq = 1'b1;
        state_next  = S_DN_DIV;
      end
      S_DN_DIV: begin
        cmd.div_dn_start = 1'b1;
        state_next       = S_TEST;
      end
      S_TEST: begin
        if (!stat.busy) begin
          if (stat.k_odd && stat.dn_is_one) begin
            cmd.set_found = 1'b1;
            state_next    = S_DONE;
          end else if (stat.k_at_limit) begin
            cmd.set_overflow = 1'b1;
            state_next       = S_DONE;
          end else begin
            cmd.commit = 1'b1;
            state_next = S_A_DIV;
          end
        end
      end
      S_A_DIV: begin
        cmd.div_a_start = 1'b1;
        state_next      = S_A_WAIT;
      end
      S_A_WAIT: begin
        if (!stat.busy) begin
          cmd.step_inc = 1'b1;
          state_next   = S_CONV_P;
        end
      end
      S_CONV_P: begin
        cmd.mul_p_start = 1'b1;
        state_next      = S_P_WAIT;
      end
      S_P_WAIT: begin
        if (!stat.busy) begin
          cmd.conv_p = 1'b1;
          state_next = S_CONV_Q;
        end
      end
      S_CONV_Q: begin
        cmd.mul_q_start = 1'b1;
        state_next      = S_Q_WAIT;
      end
      S_Q_WAIT: begin
        if (!stat.busy) begin
          cmd.conv_q = 1'b1;
          state_next = S_CONV_CHK;
        end
      end
      S_CONV_CHK: begin
        if (stat.conv_ovf) begin
          cmd.set_overflow = 1'b1;
          state_next       = S_DONE;
        end else begin
          state_next = S_MN;
        end
      end
      S_DONE: begin
        // hold the result until the output register is free
        if (!stat.out_full) begin
          cmd.out_load = 1'b1;
          state_next   = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end
endmodule

FILE: hdl/pell_fundamental_solution.sv
// channel  dir  tdata fields (low bit up)
// s_axis   in   n_value[31:0]
// m_axis   out  x_solution[63:0] y_solution[127:64] status[129:128] step_count[136:130]
// an item runs an isqrt, then for each continued fraction term two
// divisions, two shift-add multiplies and a handful of single steps,
// and ends with the final test
// s_axis_tready is high only while idle; a finished result moves to an output
// register so the next item can start while it waits, and the controller holds
// a newer result until that register is free; rst is synchronous
module pell_fundamental_solution #(
  parameter int N_WIDTH      = 32,
  parameter int RESULT_WIDTH = 64
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  input  logic [31:0]  s_axis_tdata,   // n_value
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  output logic [143:0] m_axis_tdata    // x_solution, y_solution, status, step_count
);
  import pfs_pkg::*;

  dp_cmd_t     cmd;
  dp_stat_t    stat;
  logic [63:0] x_s, y_s;
  logic [1:0]  st;
  logic [6:0]  k;

  pfs_controller u_ctrl (
    .clk(clk), .rst(rst),
    .in_fire(s_axis_tvalid & s_axis_tready),
    .stat(stat), .cmd(cmd),
    .in_ready(s_axis_tready)
  );

  pfs_datapath #(.N_WIDTH(N_WIDTH), .RESULT_WIDTH(RESULT_WIDTH)) u_dp (
    .clk(clk), .rst(rst), .n_in(s_axis_tdata), .cmd(cmd),
    .out_fire(m_axis_tvalid & m_axis_tready), .stat(stat),
    .out_valid(m_axis_tvalid),
    .x_out(x_s), .y_out(y_s), .status_out(st), .step_out(k)
  );

  assign m_axis_tdata = {7'd0, k, st, y_s, x_s};
endmodule

FILE: tb/tb_pell_fundamental_solution.sv
// testbench for pell_fundamental_solution: drives n values, predicts the pell answer
// depends on pfs_pkg and the pell_fundamental_solution rtl
module tb_pell_fundamental_solution;
  import pfs_pkg::*;

  typedef struct {
    logic [63:0] x;
    logic [63:0] y;
    logic [1:0]  status;
    logic [6:0]  steps;
  } pell_answer_t;

  class pell_scoreboard;
    pell_answer_t pending[$];
    int errors = 0;

    function logic [63:0] int_sqrt(logic [63:0] v);
      logic [63:0] res, bits;
      res = 0;
      bits = 64'd1 << 62;
      while (bits > v) bits = bits >> 2;
      while (bits != 0) begin
        if (v >= res + bits) begin
          v = v - (res + bits);
          res = (res >> 1) + bits;
        end else begin
          res = res >> 1;
        end
        bits = bits >> 2;
      end
      return res;
    endfunction

    // next = a*cur + prev, 0 returned when over 64 bits
    function bit grow(logic [63:0] a, logic [63:0] cur, logic [63:0] prev,
                      output logic [63:0] nxt);
      logic [127:0] full;
      full = a * cur + {64'd0, prev};
      nxt = full[63:0];
      return full[127:64] == 0;
    endfunction

    function void note_n(logic [31:0] nin);
      pell_answer_t r;
      logic [63:0] n, a0, m, d, a, p, pp, q, qp, mn, dn, np, nq;
      int k;
      n = {32'd0, nin};
      a0 = int_sqrt(n);
      m = 0; d = 1; a = a0; p = a0; pp = 1; q = 1; qp = 0; k = 0;
      r.x = 0; r.y = 0; r.status = ST_FOUND;
      if (n == 0 || a0 * a0 == n) begin
        r.status = ST_INVALID;
      end else begin
        forever begin
          mn = a * d - m;
          dn = (n - mn * mn) / d;
          if (k[0] && dn == 1) begin
            r.x = p; r.y = q; r.status = ST_FOUND;
            break;
          end
          if (k >= STEP_LIMIT) begin
            r.status = ST_OVERFLOW;
            break;
          end
          m = mn; d = dn; a = (a0 + m) / d; k++;
          if (!grow(a, p, pp, np) || !grow(a, q, qp, nq)) begin
            r.status = ST_OVERFLOW;
            break;
          end
          pp = p; p = np; qp = q; q = nq;
        end
      end
      r.steps = k[6:0];
      pending.push_back(r);
    endfunction

    function void check_answer(logic [143:0] data);
      pell_answer_t e;
      if (pending.size() == 0) begin
        $display("%0t unexpected result %h", $time, data);
        errors++;
        return;
      end
      e = pending.pop_front();
      if (data[63:0] !== e.x) begin
        $display("%0t x exp %0d got %0d", $time, e.x, data[63:0]); errors++;
      end
      if (data[127:64] !== e.y) begin
        $display("%0t y exp %0d got %0d", $time, e.y, data[127:64]); errors++;
      end
      if (data[129:128] !== e.status) begin
        $display("%0t status exp %0d got %0d", $time, e.status, data[129:128]); errors++;
      end
      if (data[136:130] !== e.steps) begin
        $display("%0t steps exp %0d got %0d", $time, e.steps, data[136:130]); errors++;
      end
    endfunction
  endclass

  logic clk = 0, rst = 1;
  logic s_axis_tvalid = 0, m_axis_tready = 0;
  logic [31:0] s_axis_tdata = 0;
  logic s_axis_tready, m_axis_tvalid;
  logic [143:0] m_axis_tdata;
  int send_idle = 0, recv_stall = 0, hold_cnt = 0;
  bit hold_go = 0;
  pell_scoreboard sb;
  // directed: zero, squares, small values, known long expansions, extremes
  logic [31:0] directed [24] = '{0, 1, 2, 3, 4, 5, 7, 13, 61, 109, 151, 661, 991, 1000,
                                 65535, 65536, 65537, 32'hFFFE0001, 32'hFFFE0002,
                                 32'hFFFFFFFE, 32'hFFFFFFFF, 32'h80000000, 32'h55555555,
                                 32'hAAAAAAAA};

  always #1 clk = ~clk;

  pell_fundamental_solution uut (.*);

  // receiver: random stalls plus one long hold-off
  always @(posedge clk) begin
    if (!rst) begin
      if (m_axis_tvalid && m_axis_tready) sb.check_answer(m_axis_tdata);
      if (hold_go && hold_cnt < 3000) begin
        m_axis_tready <= 0;
      end else begin
        m_axis_tready <= ($urandom_range(99) >= recv_stall);
      end
    end
  end

  // hold-off length in cycles
  always @(posedge clk) begin
    if (hold_go && hold_cnt < 3000) hold_cnt <= hold_cnt + 1;
  end

  task automatic send_n(logic [31:0] n);
    if ($urandom_range(99) < send_idle) begin
      s_axis_tvalid <= 0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle) @(posedge clk);
    end
    s_axis_tvalid <= 1;
    s_axis_tdata <= n;
    do @(posedge clk); while (!s_axis_tready);
    sb.note_n(n);
  endtask

  task automatic drain();
    s_axis_tvalid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);
  endtask

  function automatic logic [31:0] rand_n();
    logic [31:0] r, s;
    case ($urandom_range(4))
      0: rand_n = $urandom();
      1: rand_n = $urandom_range(1000);
      2: rand_n = $urandom_range(100000);
      3: begin
        s = $urandom_range(65535);
        rand_n = s * s + $urandom_range(2) - 1;
      end
      default: begin
        r = $urandom();
        rand_n = r >> $urandom_range(31);
      end
    endcase
  endfunction

  initial begin
    sb = new();
    repeat (11) @(posedge clk);
    rst <= 0;
    @(posedge clk);
    foreach (directed[i]) send_n(directed[i]);
    drain();
    for (int ph = 0; ph < 4; ph++) begin
      send_idle = (ph == 1 || ph == 3) ? ((ph == 1) ? 59 : 36) : 0;
      recv_stall = (ph == 2) ? 59 : (ph == 3) ? 36 : 0;
      if (ph == 2) hold_go <= 1;
      for (int i = 0; i < 70; i++) send_n(rand_n());
    end
    drain();
    if (sb.errors == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

  initial begin
    #40000000;
    $display("FAIL");
    $finish;
  end
endmodule

FILE: pell_fundamental_solution.f
hdl/pfs_pkg.sv
hdl/pfs_divider.sv
hdl/pfs_datapath.sv
hdl/pfs_controller.sv
hdl/pell_fundamental_solution.sv
tb/tb_pell_fundamental_solution.sv
